// ----- rtl/core/wpl_pkg.sv -----
// ----------------------------------------------------------------------------
// wpl_pkg
// Types, character codes and the per-character parse step for the waypoint
// line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wpl_pkg;

  localparam int INT_W    = 17;
  localparam int FRAC_W   = 20;
  localparam int BUDGET_W = 6;
  localparam int MICRO_W  = 37;

  localparam logic [INT_W-1:0] INT_CAP = 17'd99999;
  localparam logic [2:0]       FRAC_MAX_DIGITS = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [1:0] FIELD_ALT = 2'd2;

  localparam logic [16:0] FRAC_WEIGHT [8] = '{
    17'd100000, 17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1, 17'd0, 17'd0
  };

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_STORED,
    ST_FORMAT,
    ST_FULL
  } status_t;

  typedef struct packed {
    phase_t            phase;
    logic [1:0]        field;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [2:0]        fdig;
    logic [INT_W-1:0]  lon_int;
    logic [FRAC_W-1:0] lon_frac;
    logic [INT_W-1:0]  lat_int;
    logic [FRAC_W-1:0] lat_frac;
    logic              failed;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase: PH_SPACE, field: 2'd0, int_acc: '0, frac_acc: '0, fdig: 3'd0,
    lon_int: '0, lon_frac: '0, lat_int: '0, lat_frac: '0, failed: 1'b0
  };

  function automatic parse_state_t close_field(parse_state_t s);
    parse_state_t n;
    n = s;
    if (s.field == 2'd0) begin
      n.lon_int  = s.int_acc;
      n.lon_frac = s.frac_acc;
    end else if (s.field == 2'd1) begin
      n.lat_int  = s.int_acc;
      n.lat_frac = s.frac_acc;
    end
    if (s.field == FIELD_ALT) begin
      n.phase = PH_DONE;
    end else begin
      n.field    = s.field + 2'd1;
      n.phase    = PH_SPACE;
      n.int_acc  = '0;
      n.frac_acc = '0;
      n.fdig     = 3'd0;
    end
    return n;
  endfunction

  function automatic parse_state_t feed_char(parse_state_t s, logic [7:0] c,
                                             logic [2:0] keep);
    parse_state_t n;
    logic         digit;
    logic         ends;
    logic [3:0]   d;
    logic [19:0]  grow;
    logic [20:0]  term;
    n     = s;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    ends  = (c == CH_COMMA) || (c == CH_NUL);
    d     = c[3:0];
    grow  = 20'({3'd0, s.int_acc} * 20'd10) + {16'd0, d};
    term  = 21'({17'd0, d} * {4'd0, FRAC_WEIGHT[s.fdig]});
    if (!s.failed && s.phase != PH_DONE) begin
      case (s.phase)
        PH_SPACE: begin
          if (digit) begin
            n.int_acc  = {13'd0, d};
            n.frac_acc = '0;
            n.phase    = PH_INT;
          end else if (c != CH_SPACE) begin
            n.failed = 1'b1;
          end
        end
        PH_INT: begin
          if (digit) begin
            n.int_acc = (grow > {3'd0, INT_CAP}) ? INT_CAP : grow[INT_W-1:0];
          end else if (c == CH_DOT) begin
            n.frac_acc = '0;
            n.fdig     = 3'd0;
            n.phase    = PH_FRAC;
          end else if (ends && s.field == FIELD_ALT) begin
            n = close_field(s);
          end else begin
            n.failed = 1'b1;
          end
        end
        PH_FRAC: begin
          if (digit) begin
            if (s.fdig < keep) begin
              if (s.fdig < FRAC_MAX_DIGITS) begin
                n.frac_acc = s.frac_acc + term[FRAC_W-1:0];
              end
              n.fdig = s.fdig + 3'd1;
            end
          end else if (ends) begin
            n = close_field(s);
          end else begin
            n.failed = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (c == CH_NUL && !n.failed && n.phase != PH_DONE) begin
        n.failed = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wpl_micro_scale.sv -----
// ----------------------------------------------------------------------------
// wpl_micro_scale
// Joins an integer part and a fraction in millionths into one fixed-point
// value in millionths.
// ----------------------------------------------------------------------------
`default_nettype none

module wpl_micro_scale
  import wpl_pkg::*;
(
  input  wire logic [INT_W-1:0]   int_part,
  input  wire logic [FRAC_W-1:0]  frac_part,
  output logic      [MICRO_W-1:0] value
);

  logic [MICRO_W-1:0] scaled;

  assign scaled = MICRO_W'({20'd0, int_part} * 37'd1000000);
  assign value  = scaled + {17'd0, frac_part};

endmodule

`default_nettype wire

// ----- rtl/core/waypoint_line_parser_core.sv -----
// ----------------------------------------------------------------------------
// waypoint_line_parser_core
// Parses waypoint text, one byte per transaction, into fixed-point waypoints.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters on text_valid/text_ready/text_byte, one byte per transaction.
//   A line ends at carriage return or when LINE_LIMIT-1 non-CR bytes have
//   been taken. At each line end one transaction leaves on result_valid/
//   result_ready carrying status, slot, the three values and stored_count.
//   Each byte is parsed in the cycle it is accepted; the result of a line
//   end is registered and shows in the cycle after the closing byte.
//   Throughput is one byte per cycle, set by the combinational parse step
//   between the parse state and result registers, unless a line end waits.
//   While a result is stalled, bytes that do not end a line keep flowing;
//   a byte that would end a line waits until the result register is free.
//   Reset clears the line state, empties the result register and sets the
//   next free slot to 1. Once TABLE_SLOTS is reached every line reports full.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_line_parser_core
  import wpl_pkg::*;
#(
  parameter int LINE_LIMIT    = 48,
  parameter int TABLE_SLOTS   = 8,
  parameter int FRACTION_KEEP = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         text_valid,
  output logic              text_ready,
  input  wire logic [7:0]   text_byte,
  output logic              result_valid,
  input  wire logic         result_ready,
  output logic [1:0]        line_status,
  output logic [2:0]        slot_index,
  output logic [36:0]       longitude_micro,
  output logic [36:0]       latitude_micro,
  output logic [36:0]       altitude_micro,
  output logic [3:0]        stored_count
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [BUDGET_W-1:0] BUDGET_INIT = BUDGET_W'(LINE_LIMIT - 1);
  localparam logic [SLOT_W-1:0]   SLOT_FULL   = SLOT_W'(TABLE_SLOTS);
  localparam logic [2:0]          KEEP        = 3'(FRACTION_KEEP);

  parse_state_t        pstate;
  parse_state_t        pstate_next;
  parse_state_t        after_byte;
  parse_state_t        after_end;
  logic [BUDGET_W-1:0] budget;
  logic [SLOT_W-1:0]   next_slot;
  logic                line_end;
  logic                accept;

  status_t             res_status;
  logic [SLOT_W+3:0]   res_slot;
  logic [SLOT_W+3:0]   res_count;
  logic [INT_W-1:0]    res_lon_int;
  logic [FRAC_W-1:0]   res_lon_frac;
  logic [INT_W-1:0]    res_lat_int;
  logic [FRAC_W-1:0]   res_lat_frac;
  logic [INT_W-1:0]    res_alt_int;
  logic [FRAC_W-1:0]   res_alt_frac;

  assign line_end   = (text_byte == CH_CR) || (budget == BUDGET_W'(1));
  assign text_ready = !result_valid || result_ready || !line_end;
  assign accept     = text_valid && text_ready;

  always_comb begin
    if (text_byte == CH_CR || text_byte == CH_LF) begin
      after_byte = pstate;
    end else begin
      after_byte = feed_char(pstate, text_byte, KEEP);
    end
    after_end   = feed_char(after_byte, CH_NUL, KEEP);
    pstate_next = line_end ? PARSE_CLEAR : after_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= PARSE_CLEAR;
      budget    <= BUDGET_INIT;
      next_slot <= SLOT_W'(1);
    end else if (accept) begin
      pstate <= pstate_next;
      budget <= line_end ? BUDGET_INIT : budget - BUDGET_W'(1);
      if (line_end && next_slot < SLOT_FULL && !after_end.failed &&
          after_end.phase == PH_DONE) begin
        next_slot <= next_slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && line_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && line_end) begin
      res_slot     <= '0;
      res_count    <= {4'd0, next_slot};
      res_lon_int  <= '0;
      res_lon_frac <= '0;
      res_lat_int  <= '0;
      res_lat_frac <= '0;
      res_alt_int  <= '0;
      res_alt_frac <= '0;
      if (next_slot >= SLOT_FULL) begin
        res_status <= ST_FULL;
      end else if (after_end.failed || after_end.phase != PH_DONE) begin
        res_status <= ST_FORMAT;
      end else begin
        res_status   <= ST_STORED;
        res_slot     <= {4'd0, next_slot};
        res_count    <= {4'd0, next_slot} + (SLOT_W+4)'(1);
        res_lon_int  <= after_end.lon_int;
        res_lon_frac <= after_end.lon_frac;
        res_lat_int  <= after_end.lat_int;
        res_lat_frac <= after_end.lat_frac;
        res_alt_int  <= after_end.int_acc;
        res_alt_frac <= after_end.frac_acc;
      end
    end
  end

  wpl_micro_scale u_lon_scale (
    .int_part  (res_lon_int),
    .frac_part (res_lon_frac),
    .value     (longitude_micro)
  );

  wpl_micro_scale u_lat_scale (
    .int_part  (res_lat_int),
    .frac_part (res_lat_frac),
    .value     (latitude_micro)
  );

  wpl_micro_scale u_alt_scale (
    .int_part  (res_alt_int),
    .frac_part (res_alt_frac),
    .value     (altitude_micro)
  );

  assign line_status  = res_status;
  assign slot_index   = res_slot[2:0];
  assign stored_count = res_count[3:0];

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    next_slot >= SLOT_W'(1) && next_slot <= SLOT_FULL)
    else $error("next slot out of range");

  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && next_slot != $past(next_slot)) |->
      (result_valid && res_status == ST_STORED))
    else $error("slot advanced without a stored waypoint transaction");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> (result_valid && !result_ready && line_end))
    else $error("text input blocked without a stalled result");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for waypoint_line_parser_core. Streams waypoint text bytes in,
// runs a cycle-free line parser model on every accepted byte, and checks each
// line result field by field in order. Covers empty, malformed, truncated,
// saturating and budget-terminated lines and the table-full state, under
// four backpressure profiles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import wpl_pkg::*;

  localparam int LINE_LIMIT    = 48;
  localparam int TABLE_SLOTS   = 8;
  localparam int FRACTION_KEEP = 6;
  localparam int PHASE_BYTES   = 500;
  localparam logic [36:0] MICRO = 37'd1000000;

  typedef struct {
    status_t     status;
    logic [2:0]  slot;
    logic [36:0] lon;
    logic [36:0] lat;
    logic [36:0] alt;
    logic [3:0]  count;
  } waypoint_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_byte = 8'd0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  line_status;
  logic [2:0]  slot_index;
  logic [36:0] longitude_micro;
  logic [36:0] latitude_micro;
  logic [36:0] altitude_micro;
  logic [3:0]  stored_count;

  logic [7:0] text_q[$];
  waypoint_t  waypoint_q[$];
  bit         text_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         errors = 0;
  int         line_len = 0;

  // parser model state
  phase_t      pm_phase = PH_SPACE;
  logic [1:0]  pm_field = '0;
  logic [36:0] pm_acc = '0;
  logic [2:0]  pm_fdig = '0;
  logic [5:0]  pm_budget = 6'(LINE_LIMIT - 1);
  logic [36:0] pm_lon = '0;
  logic [36:0] pm_lat = '0;
  logic [3:0]  pm_next = 4'd1;
  bit          pm_failed = 1'b0;

  waypoint_line_parser_core #(
    .LINE_LIMIT   (LINE_LIMIT),
    .TABLE_SLOTS  (TABLE_SLOTS),
    .FRACTION_KEEP(FRACTION_KEEP)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_ready     (text_ready),
    .text_byte      (text_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .line_status    (line_status),
    .slot_index     (slot_index),
    .longitude_micro(longitude_micro),
    .latitude_micro (latitude_micro),
    .altitude_micro (altitude_micro),
    .stored_count   (stored_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  task automatic close_number();
    if (pm_phase == PH_INT) pm_acc = pm_acc * MICRO;
    if (pm_field == FIELD_ALT) begin
      pm_phase = PH_DONE;
    end else begin
      if (pm_field == 2'd0) pm_lon = pm_acc;
      else pm_lat = pm_acc;
      pm_field = pm_field + 2'd1;
      pm_phase = PH_SPACE;
      pm_acc   = '0;
      pm_fdig  = '0;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    bit          digit;
    bit          ends;
    logic [36:0] d;
    logic [36:0] w;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    ends  = (c == CH_COMMA) || (c == CH_NUL);
    d     = 37'(c - CH_ZERO);
    if (!pm_failed && pm_phase != PH_DONE) begin
      case (pm_phase)
        PH_SPACE: begin
          if (digit) begin
            pm_acc   = d;
            pm_phase = PH_INT;
          end else if (c != CH_SPACE) begin
            pm_failed = 1'b1;
          end
        end
        PH_INT: begin
          if (digit) begin
            pm_acc = pm_acc * 37'd10 + d;
            if (pm_acc > 37'(INT_CAP)) pm_acc = 37'(INT_CAP);
          end else if (c == CH_DOT) begin
            pm_acc   = pm_acc * MICRO;
            pm_fdig  = '0;
            pm_phase = PH_FRAC;
          end else if (ends && pm_field == FIELD_ALT) begin
            close_number();
          end else begin
            pm_failed = 1'b1;
          end
        end
        PH_FRAC: begin
          if (digit) begin
            if (pm_fdig < FRACTION_KEEP) begin
              if (pm_fdig < 3'd6) begin
                w = 37'd100000;
                repeat (pm_fdig) w = w / 37'd10;
                pm_acc = pm_acc + d * w;
              end
              pm_fdig = pm_fdig + 3'd1;
            end
          end else if (ends) begin
            close_number();
          end else begin
            pm_failed = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (c == CH_NUL && !pm_failed && pm_phase != PH_DONE) pm_failed = 1'b1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c);
    waypoint_t wp;
    if (c == CH_CR) begin
      pm_budget = '0;
    end else begin
      if (c != CH_LF) take_char(c);
      pm_budget = pm_budget - 6'd1;
    end
    if (pm_budget == '0) begin
      take_char(CH_NUL);
      wp.status = ST_STORED;
      wp.slot   = '0;
      wp.lon    = '0;
      wp.lat    = '0;
      wp.alt    = '0;
      if (pm_next >= TABLE_SLOTS) begin
        wp.status = ST_FULL;
      end else if (pm_failed || pm_phase != PH_DONE) begin
        wp.status = ST_FORMAT;
      end else begin
        wp.slot = pm_next[2:0];
        wp.lon  = pm_lon;
        wp.lat  = pm_lat;
        wp.alt  = pm_acc;
        pm_next = pm_next + 4'd1;
      end
      wp.count = pm_next;
      waypoint_q.push_back(wp);
      pm_phase  = PH_SPACE;
      pm_field  = '0;
      pm_acc    = '0;
      pm_fdig   = '0;
      pm_budget = 6'(LINE_LIMIT - 1);
      pm_lon    = '0;
      pm_lat    = '0;
      pm_failed = 1'b0;
    end
  endtask

  // ------------------------------------------------------------ stimulus
  task automatic put(input logic [7:0] b);
    text_q.push_back(b);
    if (b != CH_CR) line_len++;
  endtask

  task automatic add_number(input bit is_alt);
    int nint;
    int nfr;
    repeat ($urandom_range(0, 2)) put(CH_SPACE);
    nint = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 7);
    repeat (nint) put(CH_ZERO + 8'($urandom_range(0, 9)));
    if (!is_alt || $urandom_range(0, 1)) begin
      put(CH_DOT);
      nfr = $urandom_range(0, 8);
      repeat (nfr) put(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_line();
    int       kind;
    int       ending;
    int       pos;
    int       start;
    logic [7:0] b;
    kind     = $urandom_range(0, 99);
    line_len = 0;
    start    = text_q.size();
    if (kind < 85) begin
      if ($urandom_range(0, 9) == 0) put(CH_LF);
      add_number(1'b0);
      put(CH_COMMA);
      add_number(1'b0);
      if (kind < 78 || kind > 84) begin
        put(CH_COMMA);
        add_number(1'b1);
      end
      if (kind >= 70 && kind < 78) begin
        pos = $urandom_range(start, text_q.size() - 1);
        text_q[pos] = 8'($urandom_range(0, 255));
      end
      ending = $urandom_range(0, 9);
      if (ending == 5 || ending == 6) begin
        put(CH_COMMA);
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(97, 122)));
      end else if (ending == 7) begin
        put(CH_NUL);
        repeat ($urandom_range(0, 4)) put(8'($urandom_range(33, 126)));
      end
      if (ending >= 8) begin
        put(CH_COMMA);
        while (line_len < LINE_LIMIT - 1) begin
          b = 8'($urandom_range(0, 255));
          if (b != CH_CR) put(b);
        end
      end else begin
        put(CH_CR);
      end
    end else begin
      repeat ($urandom_range(1, 60)) put(8'($urandom_range(0, 255)));
    end
  endtask

  // -------------------------------------------------------- driver/monitor
  always @(negedge clk) begin
    if (rst) begin
      text_valid   <= 1'b0;
      result_ready <= 1'b0;
      text_taken    = 1'b0;
    end else begin
      if (!text_valid || text_taken) begin
        text_taken = 1'b0;
        if (text_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          text_valid <= 1'b1;
          text_byte  <= text_q[0];
        end else begin
          text_valid <= 1'b0;
          text_byte  <= 8'($urandom);
        end
      end
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    waypoint_t wp;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (waypoint_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d slot %0d cnt %0d",
                     line_status, slot_index, stored_count);
        end else begin
          wp = waypoint_q.pop_front();
          if (line_status !== wp.status || slot_index !== wp.slot ||
              longitude_micro !== wp.lon || latitude_micro !== wp.lat ||
              altitude_micro !== wp.alt || stored_count !== wp.count) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: st %0d slot %0d lon %0d lat %0d alt %0d cnt %0d",
                       wp.status, wp.slot, wp.lon, wp.lat, wp.alt, wp.count);
              $display("         got: st %0d slot %0d lon %0d lat %0d alt %0d cnt %0d",
                       line_status, slot_index, longitude_micro, latitude_micro,
                       altitude_micro, stored_count);
            end
          end
        end
      end
      if (text_valid && text_ready) begin
        parse_byte(text_byte);
        void'(text_q.pop_front());
        text_taken = 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- main
  initial begin
    string s;
    int    ph;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty line, saturation with extra fraction digits and a
    // pointless altitude, and a NUL followed by an all-ones byte
    put(CH_CR);
    s = "123456.1234567,0.,5";
    for (int i = 0; i < s.len(); i++) put(s[i]);
    put(CH_CR);
    put(CH_NUL);
    put(8'hFF);
    put(CH_CR);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      while (text_q.size() < PHASE_BYTES) add_line();
      while (text_q.size() > 0) @(posedge clk);
    end

    while (waypoint_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (waypoint_q.size() > 0) errors++;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wpl_pkg.sv
rtl/core/wpl_micro_scale.sv
rtl/core/waypoint_line_parser_core.sv
bench/tb_top.sv
